// ----- hw/rtl/sust_pkg.sv -----
// shared types and codes for the sorted unique set table
`default_nettype none

package sust_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // commands broadcast to every cell of the chain
  localparam logic [2:0] CMD_HOLD   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_ROTATE = 3'd4;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [2:0] code;
    value_t     key;
  } cell_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic   valid;
    logic   below;
    value_t val;
  } cell_link_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sust_cell.sv -----
// one cell of the sorted chain: holds one value and its occupied flag
`default_nettype none

module sust_cell (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sust_pkg::cell_cmd_t    cmd,
  input  wire sust_pkg::cell_link_t   left,
  input  wire sust_pkg::cell_link_t   right,
  input  wire sust_pkg::value_t       head,
  output sust_pkg::cell_link_t        link,
  output logic                        eq
);

  sust_pkg::value_t val;
  logic             valid;
  sust_pkg::value_t val_next;
  logic             valid_next;
  logic             below;

  // compare stored value against the broadcast key
  assign below = valid && (val < cmd.key);
  assign eq    = valid && (val == cmd.key);

  assign link.valid = valid;
  assign link.below = below;
  assign link.val   = val;

  // next content from the command and the neighbors
  always_comb begin
    val_next   = val;
    valid_next = valid;
    case (cmd.code)
      sust_pkg::CMD_INSERT: begin
        if (!below) begin
          if (left.below) begin
            val_next   = cmd.key;
            valid_next = 1'b1;
          end else begin
            val_next   = left.val;
            valid_next = left.valid;
          end
        end
      end
      sust_pkg::CMD_DELETE: begin
        if (!below) begin
          val_next   = right.val;
          valid_next = right.valid;
        end
      end
      sust_pkg::CMD_CLEAR: begin
        valid_next = 1'b0;
      end
      sust_pkg::CMD_ROTATE: begin
        if (valid) begin
          val_next = right.valid ? right.val : head;
        end
      end
      default: begin
        val_next   = val;
        valid_next = valid;
      end
    endcase
  end

  // occupied flag is control state, value is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sust_chain.sv -----
// row of cells kept in ascending order, with hit detect and head tap
`default_nettype none

module sust_chain #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sust_pkg::cell_cmd_t cmd,
  output sust_pkg::value_t         head,
  output logic                     hit
);

  sust_pkg::cell_link_t links [CAPACITY];
  logic [CAPACITY-1:0]  eq_vec;
  sust_pkg::cell_link_t edge_left;
  sust_pkg::cell_link_t edge_right;

  // boundary links: the first cell sees a smaller neighbor, the last an empty one
  assign edge_left.valid  = 1'b1;
  assign edge_left.below  = 1'b1;
  assign edge_left.val    = '0;
  assign edge_right.valid = 1'b0;
  assign edge_right.below = 1'b0;
  assign edge_right.val   = '0;

  assign head = links[0].val;
  assign hit  = |eq_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sust_pkg::cell_link_t left_link;
    sust_pkg::cell_link_t right_link;

    if (i == 0) begin : g_first
      assign left_link = edge_left;
    end else begin : g_mid_l
      assign left_link = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_link = edge_right;
    end else begin : g_mid_r
      assign right_link = links[i+1];
    end

    sust_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (left_link),
      .right (right_link),
      .head  (links[0].val),
      .link  (links[i]),
      .eq    (eq_vec[i])
    );
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_unique_set_table_core.sv -----
// top level: sorted set of distinct signed values, command interface
//
// Usage: drive op and value with start high while busy is low; that edge
// takes the beat. Insert, delete and clear give one result beat, registered
// at the end of the execute state: during that state the key is compared in
// every cell at once, and the edge that ends it both shifts the chain and
// registers the result. No new command is taken until busy has dropped.
// Dump gives one result beat per stored value in ascending order with last on
// the final one (or a single set-empty beat when the set is empty); after the
// execute state the value beats come back to back, since the chain rotates
// one place per cycle and presents its head cell. Each result beat is on
// status, out_value, last and count_after for one cycle, marked by done;
// the receiver cannot stall, so nothing is held back. busy drops in the
// cycle that carries the final result beat, so the next command can be
// taken at the edge that ends it. Reset empties the set and drops done;
// stored values themselves are not cleared, only their occupied flags.
`default_nettype none

module sorted_unique_set_table_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          op,
  input  wire logic signed [31:0]  value,
  output logic                     done,
  output logic [2:0]               status,
  output logic signed [31:0]       out_value,
  output logic                     last,
  output logic [4:0]               count_after
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]           state;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CW-1:0]        idx;
  logic [1:0]           op_r;
  sust_pkg::value_t     key_r;
  logic [2:0]           status_next;
  sust_pkg::cell_cmd_t  cmd;
  sust_pkg::value_t     head;
  logic                 hit;

  assign busy = (state != S_IDLE);

  sust_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .head (head),
    .hit  (hit)
  );

  // decide status, chain command and new count
  always_comb begin
    cmd.code    = sust_pkg::CMD_HOLD;
    cmd.key     = key_r;
    status_next = sust_pkg::ST_OK;
    count_next  = count;
    unique case (state)
      S_EXEC: begin
        case (op_r)
          sust_pkg::OP_INSERT: begin
            if (hit) begin
              status_next = sust_pkg::ST_DUP;
            end else if (count == CW'(CAPACITY)) begin
              status_next = sust_pkg::ST_FULL;
            end else begin
              cmd.code   = sust_pkg::CMD_INSERT;
              count_next = count + CW'(1);
            end
          end
          sust_pkg::OP_DELETE: begin
            if (count == '0) begin
              status_next = sust_pkg::ST_EMPTY;
            end else if (!hit) begin
              status_next = sust_pkg::ST_MISSING;
            end else begin
              cmd.code   = sust_pkg::CMD_DELETE;
              count_next = count - CW'(1);
            end
          end
          sust_pkg::OP_CLEAR: begin
            cmd.code   = sust_pkg::CMD_CLEAR;
            count_next = '0;
          end
          default: begin
            if (count == '0) begin
              status_next = sust_pkg::ST_EMPTY;
            end
          end
        endcase
      end
      S_DUMP: begin
        cmd.code = sust_pkg::CMD_ROTATE;
      end
      S_IDLE: begin
        cmd.code = sust_pkg::CMD_HOLD;
      end
      default: begin
        cmd.code = sust_pkg::CMD_HOLD;
      end
    endcase
  end

  // sequencer and result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          count <= count_next;
          if (op_r == sust_pkg::OP_DUMP && count != '0) begin
            state <= S_DUMP;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DUMP: begin
          done <= 1'b1;
          if (idx == count - CW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_r  <= op;
      key_r <= value;
    end
    if (state == S_EXEC) begin
      idx         <= '0;
      status      <= status_next;
      out_value   <= '0;
      last        <= 1'b1;
      count_after <= 5'(count_next);
    end else if (state == S_DUMP) begin
      idx         <= idx + CW'(1);
      status      <= sust_pkg::ST_OK;
      out_value   <= head;
      last        <= (idx == count - CW'(1));
      count_after <= 5'(count);
    end
  end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the sorted unique set table core
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned TABLE_DEPTH    = 16;
  localparam int          RANDOM_ITEMS   = 250;
  localparam int          DRAIN_CYCLES   = 2 * TABLE_DEPTH + 8;
  localparam int          WATCHDOG_LIMIT = 2000;

  // one expected result beat
  typedef struct {
    logic [2:0]       status;
    sust_pkg::value_t data;
    logic             last;
    logic [4:0]       count;
  } set_beat_t;

  // mirror of the stored set plus the queue of beats it predicts
  class sorted_set_tracker;
    sust_pkg::value_t members[$];
    set_beat_t        pending_beats[$];
    int               mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void push_beat(logic [2:0] st, sust_pkg::value_t data, logic lst);
      set_beat_t b;
      b.status = st;
      b.data   = data;
      b.last   = lst;
      b.count  = 5'(members.size());
      pending_beats.push_back(b);
    endfunction

    // first slot whose value is not below key
    function int lower_slot(sust_pkg::value_t key);
      int i;
      i = 0;
      while (i < members.size() && members[i] < key) i++;
      return i;
    endfunction

    // apply an accepted command and predict its beats
    function void note_command(logic [1:0] code, sust_pkg::value_t key);
      int pos;
      pos = lower_slot(key);
      case (code)
        sust_pkg::OP_INSERT: begin
          if (pos < members.size() && members[pos] == key) begin
            push_beat(sust_pkg::ST_DUP, '0, 1'b1);
          end else if (members.size() >= TABLE_DEPTH) begin
            push_beat(sust_pkg::ST_FULL, '0, 1'b1);
          end else begin
            members.insert(pos, key);
            push_beat(sust_pkg::ST_OK, '0, 1'b1);
          end
        end
        sust_pkg::OP_DELETE: begin
          if (members.size() == 0) begin
            push_beat(sust_pkg::ST_EMPTY, '0, 1'b1);
          end else if (pos >= members.size() || members[pos] != key) begin
            push_beat(sust_pkg::ST_MISSING, '0, 1'b1);
          end else begin
            members.delete(pos);
            push_beat(sust_pkg::ST_OK, '0, 1'b1);
          end
        end
        sust_pkg::OP_CLEAR: begin
          members.delete();
          push_beat(sust_pkg::ST_OK, '0, 1'b1);
        end
        default: begin
          if (members.size() == 0) begin
            push_beat(sust_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            foreach (members[i])
              push_beat(sust_pkg::ST_OK, members[i], i == members.size() - 1);
          end
        end
      endcase
    endfunction

    // compare one result beat with the oldest prediction
    function void check_beat(logic [2:0] st, sust_pkg::value_t data, logic lst,
                             logic [4:0] cnt);
      set_beat_t b;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: status %0d value %0d", st, data);
        mismatches++;
        return;
      end
      b = pending_beats.pop_front();
      if (st !== b.status) begin
        $error("status: expected %0d, actual %0d", b.status, st);
        mismatches++;
      end
      if (data !== b.data) begin
        $error("out_value: expected %0d, actual %0d", b.data, data);
        mismatches++;
      end
      if (lst !== b.last) begin
        $error("last: expected %0b, actual %0b", b.last, lst);
        mismatches++;
      end
      if (cnt !== b.count) begin
        $error("count_after: expected %0d, actual %0d", b.count, cnt);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_beats.size();
    endfunction

    function int fill();
      return members.size();
    endfunction

    function sust_pkg::value_t pick_member();
      return members[$urandom_range(0, members.size() - 1)];
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       op = sust_pkg::OP_INSERT;
  sust_pkg::value_t value = '0;
  logic             busy;
  logic             done;
  logic [2:0]       status;
  sust_pkg::value_t out_value;
  logic             last;
  logic [4:0]       count_after;

  sorted_set_tracker tracker = new();
  int quiet_cycles = 0;
  int burst_left = 0;

  sorted_unique_set_table_core #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .value(value),
    .done(done),
    .status(status),
    .out_value(out_value),
    .last(last),
    .count_after(count_after)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // monitor: result beats and accepted commands at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_beat(status, out_value, last, count_after);
      if (start && !busy) tracker.note_command(op, value);
    end
  end

  // watchdog on cycles where no beat moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // drive one command beat, with random gaps between bursts
  task automatic send_beat(input logic [1:0] code, input sust_pkg::value_t key,
                           input bit paced);
    int gap;
    if (paced && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        start = 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    start = 1'b1;
    op    = code;
    value = key;
    do @(posedge clk); while (busy);
    if (burst_left > 0) burst_left--;
  endtask

  // value for a random command
  function automatic sust_pkg::value_t pick_key(logic [1:0] code);
    int r;
    r = $urandom_range(0, 9);
    if (code == sust_pkg::OP_DELETE && tracker.fill() > 0 && $urandom_range(0, 1) == 1)
      return tracker.pick_member();
    if (r < 4) return sust_pkg::value_t'($urandom);
    if (r < 7) return sust_pkg::value_t'($signed($urandom_range(0, 16)) - 8);
    if (r == 7) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return -32'sd1;
      endcase
    end
    if (tracker.fill() > 0) return tracker.pick_member();
    return sust_pkg::value_t'($urandom);
  endfunction

  initial begin
    int sent;
    int round_len;
    int r;
    bit fill_mode;
    logic [1:0] code;

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty set cases
    send_beat(sust_pkg::OP_DUMP, '0, 0);
    send_beat(sust_pkg::OP_DELETE, 32'sd5, 0);
    send_beat(sust_pkg::OP_CLEAR, '0, 0);
    // directed: extremes, duplicates, ordering
    send_beat(sust_pkg::OP_INSERT, '0, 0);
    send_beat(sust_pkg::OP_INSERT, 32'sh7fff_ffff, 0);
    send_beat(sust_pkg::OP_INSERT, 32'sh8000_0000, 0);
    send_beat(sust_pkg::OP_INSERT, -32'sd1, 0);
    send_beat(sust_pkg::OP_INSERT, 32'sd1, 0);
    send_beat(sust_pkg::OP_INSERT, '0, 0);
    send_beat(sust_pkg::OP_INSERT, 32'sh7fff_ffff, 0);
    send_beat(sust_pkg::OP_DUMP, 32'sh5555_aaaa, 0);
    // directed: delete missing, head, tail, middle
    send_beat(sust_pkg::OP_DELETE, 32'sd7, 0);
    send_beat(sust_pkg::OP_DELETE, 32'sh8000_0000, 0);
    send_beat(sust_pkg::OP_DELETE, 32'sh7fff_ffff, 0);
    send_beat(sust_pkg::OP_DELETE, '0, 0);
    send_beat(sust_pkg::OP_DUMP, '1, 0);
    // directed: clear a filled set, then empty again by delete
    send_beat(sust_pkg::OP_CLEAR, '1, 0);
    send_beat(sust_pkg::OP_DUMP, '0, 0);
    send_beat(sust_pkg::OP_INSERT, 32'sd42, 0);
    send_beat(sust_pkg::OP_DELETE, 32'sd42, 0);
    send_beat(sust_pkg::OP_DELETE, 32'sd42, 0);

    // random rounds: fill-heavy rounds favour inserts to push toward a full table, mixed rounds churn
    sent = 0;
    for (int round = 0; sent < RANDOM_ITEMS; round++) begin
      fill_mode = (round == 0) || ($urandom_range(0, 2) == 0);
      round_len = $urandom_range(20, 45);
      for (int k = 0; k < round_len; k++) begin
        r = $urandom_range(0, 99);
        if (fill_mode)
          code = (r < 70) ? sust_pkg::OP_INSERT :
                 (r < 85) ? sust_pkg::OP_DELETE : sust_pkg::OP_DUMP;
        else
          code = (r < 40) ? sust_pkg::OP_INSERT :
                 (r < 70) ? sust_pkg::OP_DELETE :
                 (r < 93) ? sust_pkg::OP_DUMP : sust_pkg::OP_CLEAR;
        send_beat(code, pick_key(code), 1);
        sent++;
      end
      if ($urandom_range(0, 1) == 1) begin
        send_beat(sust_pkg::OP_DUMP, sust_pkg::value_t'($urandom), 1);
        send_beat(sust_pkg::OP_CLEAR, sust_pkg::value_t'($urandom), 1);
        sent += 2;
      end
    end

    // drain
    @(negedge clk);
    start = 1'b0;
    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sust_pkg.sv
hw/rtl/sust_cell.sv
hw/rtl/sust_chain.sv
hw/rtl/sorted_unique_set_table_core.sv
test/testbench.sv
